### hw/rtl/iexu_pkg.sv
// ----------------------------------------------------------------------------
// iexu_pkg
// Shared types, codes and helpers for the instruction executor: command and
// opcode codes, trap vectors, event codes and the request structs that run
// between the control path, the main memory and the register file.
// ----------------------------------------------------------------------------
package iexu_pkg;

	// Sizes
	localparam int ADDR_BITS = 16;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam int WORD_W    = 16;
	localparam int REG_CNT   = 8;
	localparam int REG_IDX_W = $clog2(REG_CNT);

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Memory-mapped keyboard registers
	localparam addr_t KBSR_ADDR  = 16'hFE00;
	localparam addr_t KBDR_ADDR  = 16'hFE02;
	localparam word_t KBSR_READY = 16'h8000;

	// PC loaded by start until the host changes it
	localparam word_t START_RESET = 16'h3000;

	// Link register for calls and traps
	localparam reg_idx_t REG_LINK = 3'd7;
	localparam reg_idx_t REG_R0   = 3'd0;

	// Host commands
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_START = 2'd2,
		CMD_STEP  = 2'd3
	} cmd_t;

	// Instruction opcodes
	typedef enum logic [3:0] {
		OP_BR   = 4'd0,
		OP_ADD  = 4'd1,
		OP_LD   = 4'd2,
		OP_ST   = 4'd3,
		OP_JSR  = 4'd4,
		OP_AND  = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_RTI  = 4'd8,
		OP_NOT  = 4'd9,
		OP_LDI  = 4'd10,
		OP_STI  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RES  = 4'd13,
		OP_LEA  = 4'd14,
		OP_TRAP = 4'd15
	} op_t;

	// Trap vectors
	localparam logic [7:0] TRAP_GETC  = 8'h20;
	localparam logic [7:0] TRAP_OUT   = 8'h21;
	localparam logic [7:0] TRAP_PUTS  = 8'h22;
	localparam logic [7:0] TRAP_IN    = 8'h23;
	localparam logic [7:0] TRAP_PUTSP = 8'h24;
	localparam logic [7:0] TRAP_HALT  = 8'h25;

	// Result events
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_OUT   = 3'd1,
		EV_PUTS  = 3'd2,
		EV_PUTSP = 3'd3,
		EV_HALT  = 3'd4,
		EV_BAD   = 3'd5,
		EV_WAIT  = 3'd6
	} ev_t;

	// Condition codes
	localparam logic [2:0] CC_P = 3'd1;
	localparam logic [2:0] CC_Z = 3'd2;
	localparam logic [2:0] CC_N = 3'd4;

	// One host item as held inside the block
	typedef struct packed {
		cmd_t       command;
		addr_t      address;
		word_t      data;
		logic       key_ready;
		logic [7:0] key_char;
	} item_t;

	// Main memory request, with the key offered to a KBSR poll
	typedef struct packed {
		logic       en;
		logic       we;
		addr_t      addr;
		word_t      wdata;
		logic       key_ready;
		logic [7:0] key_char;
	} mem_req_t;

	typedef struct packed {
		word_t rdata;     // registered read data
		logic  key_take;  // this cycle's request polls KBSR with a key present
		logic  busy;      // clearing pass after reset
	} mem_rsp_t;

	// Register file request
	typedef struct packed {
		logic     rd_en;
		reg_idx_t rd_a;
		reg_idx_t rd_b;
		logic     we;
		reg_idx_t waddr;
		word_t    wdata;
	} rf_req_t;

	// Sign extension of the instruction offset fields
	function automatic word_t sext5(input word_t ins);
		return {{11{ins[4]}}, ins[4:0]};
	endfunction

	function automatic word_t sext6(input word_t ins);
		return {{10{ins[5]}}, ins[5:0]};
	endfunction

	function automatic word_t sext9(input word_t ins);
		return {{7{ins[8]}}, ins[8:0]};
	endfunction

	function automatic word_t sext11(input word_t ins);
		return {{5{ins[10]}}, ins[10:0]};
	endfunction

	// N/Z/P of a written value
	function automatic logic [2:0] cc_of(input word_t v);
		if (v == '0) begin
			return CC_Z;
		end else if (v[WORD_W-1]) begin
			return CC_N;
		end
		return CC_P;
	endfunction

endpackage

### hw/rtl/iexu_ifs.sv
// ----------------------------------------------------------------------------
// iexu channel interfaces
// Valid/ready channels for host commands, results and the start address
// register write.
// ----------------------------------------------------------------------------

// Host command channel
interface iexu_cmd_if import iexu_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	addr_t      address;
	word_t      data;
	logic       key_ready;
	logic [7:0] key_char;

	modport source (output valid, command, address, data, key_ready, key_char,
		input ready);
	modport sink (input valid, command, address, data, key_ready, key_char,
		output ready);
endinterface

// Result channel
interface iexu_res_if import iexu_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      read_data;
	word_t      program_counter;
	logic [2:0] cond_flags;
	logic [2:0] event_res;
	word_t      event_value;
	logic       key_taken;
	logic       running;

	modport source (output valid, read_data, program_counter, cond_flags, event_res,
		event_value, key_taken, running, input ready);
	modport sink (input valid, read_data, program_counter, cond_flags, event_res,
		event_value, key_taken, running, output ready);
endinterface

// Start address register write channel
interface iexu_cfg_if import iexu_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t start_address;

	modport source (output valid, start_address, input ready);
	modport sink (input valid, start_address, output ready);
endinterface

### hw/rtl/iexu_mem.sv
// ----------------------------------------------------------------------------
// iexu_mem
// 64K-word single-port main memory with registered read data, with the
// keyboard status/data registers overlaid at KBSR/KBDR and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module iexu_mem import iexu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	word_t              ram_q [MEM_WORDS];
	word_t              ram_rd_q;
	logic [ADDR_BITS:0] clr_cnt_q;
	word_t              kbdr_q;
	logic               ovl_sel_q;
	word_t              ovl_data_q;

	logic  busy;
	logic  rd_en;
	logic  wr_en;
	logic  kb_poll;
	word_t kbsr_poll;

	assign busy      = !clr_cnt_q[ADDR_BITS];
	assign rd_en     = !busy && req.en && !req.we;
	assign wr_en     = !busy && req.en && req.we;
	assign kb_poll   = rd_en && (req.addr == KBSR_ADDR);
	assign kbsr_poll = req.key_ready ? KBSR_READY : '0;

	// RAM array: clearing pass, else host/core access
	always_ff @(posedge clk) begin
		if (busy) begin
			ram_q[clr_cnt_q[ADDR_BITS-1:0]] <= '0;
		end else if (wr_en) begin
			ram_q[req.addr] <= req.wdata;
		end
		if (rd_en) begin
			ram_rd_q <= ram_q[req.addr];
		end
	end

	// Overlay read data; a KBSR poll returns the status it just set
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ovl_sel_q  <= (req.addr == KBSR_ADDR) || (req.addr == KBDR_ADDR);
			ovl_data_q <= (req.addr == KBSR_ADDR) ? kbsr_poll : kbdr_q;
		end
	end

	// Clear counter and keyboard data register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			kbdr_q    <= '0;
		end else begin
			if (busy) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (wr_en) begin
				if (req.addr == KBDR_ADDR) begin
					kbdr_q <= req.wdata;
				end
			end else if (kb_poll && req.key_ready) begin
				kbdr_q <= {8'd0, req.key_char};
			end
		end
	end

	assign rsp.rdata    = ovl_sel_q ? ovl_data_q : ram_rd_q;
	assign rsp.key_take = kb_poll && req.key_ready;
	assign rsp.busy     = busy;

endmodule

### hw/rtl/iexu_regfile.sv
// ----------------------------------------------------------------------------
// iexu_regfile
// Eight general registers: two registered read ports, one write port.
// Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module iexu_regfile import iexu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rf_req_t req,
	output word_t   rd_a,
	output word_t   rd_b
);

	word_t              rf_q [REG_CNT];
	logic [REG_CNT-1:0] vld_q;
	word_t              rd_a_q;
	word_t              rd_b_q;

	// Storage and read registers; read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.we) begin
			rf_q[req.waddr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_a_q <= vld_q[req.rd_a] ? rf_q[req.rd_a] : '0;
			rd_b_q <= vld_q[req.rd_b] ? rf_q[req.rd_b] : '0;
		end
	end

	// Written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

### hw/rtl/lc3_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// lc3_instruction_executor_unit
// 16-bit instruction-set core driven by host commands, one result per command.
// ----------------------------------------------------------------------------
// A command beat is buffered on arrival, so the next one is taken while the
// current one executes and its result waits in the output register. The
// buffer refills only after it has emptied. Host write, start and a step while
// stopped complete in the idle state; a host read passes through the read
// state. A step of operate, branch, jump, ST, STR, the other traps or GETC/IN
// without a key runs fetch, decode with register read and execute; LD, LDR,
// STI and GETC/IN with a key add one more memory access or the link write,
// and LDI one more memory access beyond that. After reset the main memory is
// cleared one word a cycle, and no command is taken during that clearing
// pass; start address writes are accepted at any time.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_unit import iexu_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	iexu_cmd_if.sink    cmd_ch,
	iexu_res_if.source  res_ch,
	iexu_cfg_if.sink    cfg_ch
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_HRD  = 7'b0000010,
		ST_DEC  = 7'b0000100,
		ST_EXE  = 7'b0001000,
		ST_MEM1 = 7'b0010000,
		ST_MEM2 = 7'b0100000,
		ST_LINK = 7'b1000000
	} state_t;

	state_t     state_q;
	item_t      buf_q;
	logic       buf_vld_q;
	item_t      cur_q;
	logic       pend_q;
	word_t      start_q;
	word_t      pc_q;
	logic [2:0] cc_q;
	logic       run_q;
	word_t      ins_q;
	word_t      rd_q;
	ev_t        ev_q;
	word_t      evv_q;
	logic       taken_q;

	logic       out_vld_q;
	word_t      out_rd_q;
	word_t      out_pc_q;
	logic [2:0] out_cc_q;
	ev_t        out_ev_q;
	word_t      out_evv_q;
	logic       out_taken_q;
	logic       out_run_q;

	mem_req_t mem_req;
	mem_rsp_t mem_rsp;
	rf_req_t  rf_req;
	word_t    rf_a;
	word_t    rf_b;

	logic       out_free;
	logic       out_load;
	logic       go;
	logic       instant;
	op_t        op;
	op_t        op_dec;
	logic [7:0] vec;
	logic       vec_key;
	word_t      pc1;
	word_t      ea;
	word_t      alu_b;
	logic       cc_we;

	iexu_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	iexu_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rf_req),
		.rd_a   (rf_a),
		.rd_b   (rf_b)
	);

	// Handshake glue
	assign cmd_ch.ready = !buf_vld_q && !mem_rsp.busy;
	assign cfg_ch.ready = 1'b1;
	assign out_free     = !out_vld_q || res_ch.ready;
	assign out_load     = (state_q == ST_IDLE) && pend_q && out_free;
	assign go           = (state_q == ST_IDLE) && buf_vld_q && (!pend_q || out_free);
	assign instant      = (buf_q.command == CMD_WRITE) || (buf_q.command == CMD_START)
		|| ((buf_q.command == CMD_STEP) && !run_q);

	// Decode helpers
	assign op      = op_t'(ins_q[15:12]);
	assign op_dec  = op_t'(mem_rsp.rdata[15:12]);
	assign vec     = ins_q[7:0];
	assign vec_key = (vec == TRAP_GETC) || (vec == TRAP_IN);
	assign pc1     = pc_q + 16'd1;
	assign ea      = ((op == OP_LDR) || (op == OP_STR)) ? (rf_a + sext6(ins_q))
		: (pc1 + sext9(ins_q));
	assign alu_b   = ins_q[5] ? sext5(ins_q) : rf_b;

	// Main memory requests
	always_comb begin
		mem_req           = '0;
		mem_req.key_ready = (state_q == ST_IDLE) ? buf_q.key_ready : cur_q.key_ready;
		mem_req.key_char  = (state_q == ST_IDLE) ? buf_q.key_char : cur_q.key_char;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					case (buf_q.command)
						CMD_WRITE: begin
							mem_req.en    = 1'b1;
							mem_req.we    = 1'b1;
							mem_req.addr  = buf_q.address;
							mem_req.wdata = buf_q.data;
						end
						CMD_READ: begin
							mem_req.en   = 1'b1;
							mem_req.addr = buf_q.address;
						end
						CMD_STEP: begin
							mem_req.en   = run_q;
							mem_req.addr = pc_q;
						end
						default: ;
					endcase
				end
			end
			ST_EXE: begin
				case (op)
					OP_LD, OP_LDR, OP_LDI, OP_STI: begin
						mem_req.en   = 1'b1;
						mem_req.addr = ea;
					end
					OP_ST, OP_STR: begin
						mem_req.en    = 1'b1;
						mem_req.we    = 1'b1;
						mem_req.addr  = ea;
						mem_req.wdata = rf_b;
					end
					default: ;
				endcase
			end
			ST_MEM1: begin
				// Second access of LDI/STI through the pointer just read
				if (op == OP_LDI) begin
					mem_req.en   = 1'b1;
					mem_req.addr = mem_rsp.rdata;
				end else if (op == OP_STI) begin
					mem_req.en    = 1'b1;
					mem_req.we    = 1'b1;
					mem_req.addr  = mem_rsp.rdata;
					mem_req.wdata = rf_b;
				end
			end
			default: ;
		endcase
	end

	// Register file requests; cc_we marks writes that update the flags
	always_comb begin
		rf_req = '0;
		cc_we  = 1'b0;
		case (state_q)
			ST_DEC: begin
				rf_req.rd_en = 1'b1;
				rf_req.rd_a  = (op_dec == OP_TRAP) ? REG_R0 : mem_rsp.rdata[8:6];
				rf_req.rd_b  = ((op_dec == OP_ST) || (op_dec == OP_STR) || (op_dec == OP_STI))
					? mem_rsp.rdata[11:9] : mem_rsp.rdata[2:0];
			end
			ST_EXE: begin
				rf_req.waddr = ins_q[11:9];
				case (op)
					OP_ADD: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = rf_a + alu_b;
						cc_we        = 1'b1;
					end
					OP_AND: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = rf_a & alu_b;
						cc_we        = 1'b1;
					end
					OP_NOT: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = ~rf_a;
						cc_we        = 1'b1;
					end
					OP_LEA: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = pc1 + sext9(ins_q);
						cc_we        = 1'b1;
					end
					OP_JSR: begin
						rf_req.we    = 1'b1;
						rf_req.waddr = REG_LINK;
						rf_req.wdata = pc1;
					end
					OP_TRAP: begin
						if (vec_key) begin
							// Key goes to R0 now, link follows in ST_LINK
							rf_req.we    = cur_q.key_ready;
							rf_req.waddr = REG_R0;
							rf_req.wdata = {8'd0, cur_q.key_char};
							cc_we        = cur_q.key_ready;
						end else if ((vec == TRAP_OUT) || (vec == TRAP_PUTS)
							|| (vec == TRAP_PUTSP) || (vec == TRAP_HALT)) begin
							rf_req.we    = 1'b1;
							rf_req.waddr = REG_LINK;
							rf_req.wdata = pc1;
						end
					end
					default: ;
				endcase
			end
			ST_MEM1: begin
				if ((op == OP_LD) || (op == OP_LDR)) begin
					rf_req.we    = 1'b1;
					rf_req.waddr = ins_q[11:9];
					rf_req.wdata = mem_rsp.rdata;
					cc_we        = 1'b1;
				end
			end
			ST_MEM2: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = ins_q[11:9];
				rf_req.wdata = mem_rsp.rdata;
				cc_we        = 1'b1;
			end
			ST_LINK: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = REG_LINK;
				rf_req.wdata = pc_q;
			end
			default: ;
		endcase
	end

	// Payload registers: command buffer and current item
	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			buf_q.command   <= cmd_t'(cmd_ch.command);
			buf_q.address   <= cmd_ch.address;
			buf_q.data      <= cmd_ch.data;
			buf_q.key_ready <= cmd_ch.key_ready;
			buf_q.key_char  <= cmd_ch.key_char;
		end
		if (go) begin
			cur_q <= buf_q;
		end
		if (state_q == ST_DEC) begin
			ins_q <= mem_rsp.rdata;
		end
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			buf_vld_q <= 1'b0;
			pend_q    <= 1'b0;
			start_q   <= START_RESET;
			pc_q      <= '0;
			cc_q      <= '0;
			run_q     <= 1'b0;
			rd_q      <= '0;
			ev_q      <= EV_NONE;
			evv_q     <= '0;
			taken_q   <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				start_q <= cfg_ch.start_address;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				buf_vld_q <= 1'b1;
			end else if (go) begin
				buf_vld_q <= 1'b0;
			end
			if (cc_we) begin
				cc_q <= cc_of(rf_req.wdata);
			end
			if (mem_rsp.key_take) begin
				taken_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (out_load) begin
						pend_q <= 1'b0;
					end
					if (go) begin
						rd_q    <= '0;
						ev_q    <= EV_NONE;
						evv_q   <= '0;
						taken_q <= mem_rsp.key_take;
						pend_q  <= instant;
						case (buf_q.command)
							CMD_READ: state_q <= ST_HRD;
							CMD_START: begin
								pc_q  <= start_q;
								run_q <= 1'b1;
							end
							CMD_STEP: begin
								if (run_q) begin
									state_q <= ST_DEC;
								end
							end
							default: ;
						endcase
					end
				end
				ST_HRD: begin
					rd_q    <= mem_rsp.rdata;
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DEC: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					pc_q    <= pc1;
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
					case (op)
						OP_BR: begin
							if ((cc_q & ins_q[11:9]) != '0) begin
								pc_q <= pc1 + sext9(ins_q);
							end
						end
						OP_JSR: pc_q <= ins_q[11] ? (pc1 + sext11(ins_q)) : rf_a;
						OP_JMP: pc_q <= rf_a;
						OP_LD, OP_LDR, OP_LDI, OP_STI: begin
							pend_q  <= 1'b0;
							state_q <= ST_MEM1;
						end
						OP_RTI, OP_RES: begin
							run_q <= 1'b0;
							ev_q  <= EV_BAD;
						end
						OP_TRAP: begin
							if (vec_key) begin
								if (cur_q.key_ready) begin
									taken_q <= 1'b1;
									pend_q  <= 1'b0;
									state_q <= ST_LINK;
								end else begin
									// No key: stay on the trap and report waiting
									pc_q <= pc_q;
									ev_q <= EV_WAIT;
								end
							end else begin
								case (vec)
									TRAP_OUT: begin
										ev_q  <= EV_OUT;
										evv_q <= rf_a;
									end
									TRAP_PUTS: begin
										ev_q  <= EV_PUTS;
										evv_q <= rf_a;
									end
									TRAP_PUTSP: begin
										ev_q  <= EV_PUTSP;
										evv_q <= rf_a;
									end
									TRAP_HALT: begin
										run_q <= 1'b0;
										ev_q  <= EV_HALT;
									end
									default: begin
										run_q <= 1'b0;
										ev_q  <= EV_BAD;
									end
								endcase
							end
						end
						default: ;
					endcase
				end
				ST_MEM1: begin
					if (op == OP_LDI) begin
						state_q <= ST_MEM2;
					end else begin
						pend_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MEM2, ST_LINK: begin
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q    <= rd_q;
			out_pc_q    <= pc_q;
			out_cc_q    <= cc_q;
			out_ev_q    <= ev_q;
			out_evv_q   <= evv_q;
			out_taken_q <= taken_q;
			out_run_q   <= run_q;
		end
	end

	assign res_ch.valid           = out_vld_q;
	assign res_ch.read_data       = out_rd_q;
	assign res_ch.program_counter = out_pc_q;
	assign res_ch.cond_flags      = out_cc_q;
	assign res_ch.event_res       = out_ev_q;
	assign res_ch.event_value     = out_evv_q;
	assign res_ch.key_taken       = out_taken_q;
	assign res_ch.running         = out_run_q;

	// Register writes only in the write-back states, never while reads are issued
	a_rf_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		rf_req.we |-> (state_q == ST_EXE || state_q == ST_MEM1 || state_q == ST_MEM2
			|| state_q == ST_LINK))
		else $error("register write outside write-back states");

	// The core stops only with a halt or bad-instruction event
	a_stop_event: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> (ev_q == EV_HALT || ev_q == EV_BAD))
		else $error("run flag cleared without stop event");

	// A key is consumed only when one was offered
	a_key_offered: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q |-> cur_q.key_ready)
		else $error("key taken without key offered");

	// Nothing starts while the memory is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rsp.busy |-> (state_q == ST_IDLE && !pend_q && !buf_vld_q))
		else $error("activity during memory clear");

endmodule

### tb/lc3_instruction_executor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lc3_instruction_executor_unit_tb
// Self-checking bench for the instruction executor. A queue-fed driver sends
// host command beats, and every accepted beat is run through a behavioral
// model of the core. A monitor compares each result beat against the oldest
// expected result. The stimulus is a short directed sequence, followed by
// random programs run at several start addresses.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_unit_tb;
	import iexu_pkg::*;

	// Expected content of one result beat
	typedef struct packed {
		word_t      read_data;
		word_t      pc;
		logic [2:0] flags;
		ev_t        ev;
		word_t      ev_value;
		logic       key_taken;
		logic       running;
	} step_result_t;

	logic clk;
	logic arst_n;

	iexu_cmd_if cmd_ch();
	iexu_res_if res_ch();
	iexu_cfg_if cfg_ch();

	lc3_instruction_executor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	// Model of the core
	bit [WORD_W-1:0] core_mem [MEM_WORDS];
	bit [WORD_W-1:0] core_gpr [REG_CNT];
	bit [WORD_W-1:0] core_pc;
	bit [2:0]        core_cc;
	bit              core_run;
	bit [WORD_W-1:0] start_pc = START_RESET;
	bit              kb_ready;
	bit [7:0]        kb_char;
	bit              kb_taken;

	// Bench bookkeeping
	item_t        pending_cmds [$];
	step_result_t expected_results [$];
	item_t        cur_cmd;
	int unsigned  open_items = 0;
	int unsigned  beats_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  rx_hold = 0;
	bit           hold_done = 1'b0;
	int unsigned  mismatch_cnt = 0;

	function automatic word_t sign_ext(input word_t v, input int unsigned bits);
		word_t upper;
		upper = '1 << bits;
		return v[bits-1] ? (v | upper) : (v & ~upper);
	endfunction

	function automatic void set_reg(input reg_idx_t r, input word_t v);
		core_gpr[r] = v;
		core_cc = (v == '0) ? CC_Z : (v[WORD_W-1] ? CC_N : CC_P);
	endfunction

	// Memory read; polling the keyboard status word latches the offered key
	function automatic word_t read_word(input addr_t a);
		if (a == KBSR_ADDR) begin
			if (kb_ready) begin
				core_mem[KBSR_ADDR] = KBSR_READY;
				core_mem[KBDR_ADDR] = {8'h00, kb_char};
				kb_taken = 1'b1;
			end else begin
				core_mem[KBSR_ADDR] = '0;
			end
		end
		return core_mem[a];
	endfunction

	// One instruction: fetch at PC, then execute
	function automatic void run_insn(output ev_t ev, output word_t ev_value);
		addr_t at;
		addr_t ea;
		word_t ins;
		word_t opnd;
		word_t t;
		op_t   op;
		ev = EV_NONE;
		ev_value = '0;
		at = core_pc;
		ins = read_word(core_pc);
		op = op_t'(ins[15:12]);
		core_pc = core_pc + 1'b1;
		case (op)
			OP_BR: begin
				if ((core_cc & ins[11:9]) != 3'd0)
					core_pc = core_pc + sign_ext(ins, 9);
			end
			OP_ADD, OP_AND: begin
				opnd = ins[5] ? sign_ext(ins, 5) : word_t'(core_gpr[ins[2:0]]);
				t = (op == OP_ADD) ? core_gpr[ins[8:6]] + opnd : core_gpr[ins[8:6]] & opnd;
				set_reg(ins[11:9], t);
			end
			OP_LD: begin
				ea = core_pc + sign_ext(ins, 9);
				set_reg(ins[11:9], read_word(ea));
			end
			OP_ST: begin
				ea = core_pc + sign_ext(ins, 9);
				core_mem[ea] = core_gpr[ins[11:9]];
			end
			OP_JSR: begin
				// target taken before the link write
				t = ins[11] ? core_pc + sign_ext(ins, 11) : word_t'(core_gpr[ins[8:6]]);
				core_gpr[REG_LINK] = core_pc;
				core_pc = t;
			end
			OP_LDR: begin
				ea = core_gpr[ins[8:6]] + sign_ext(ins, 6);
				set_reg(ins[11:9], read_word(ea));
			end
			OP_STR: begin
				ea = core_gpr[ins[8:6]] + sign_ext(ins, 6);
				core_mem[ea] = core_gpr[ins[11:9]];
			end
			OP_NOT: begin
				t = ~core_gpr[ins[8:6]];
				set_reg(ins[11:9], t);
			end
			OP_LDI: begin
				ea = core_pc + sign_ext(ins, 9);
				ea = read_word(ea);
				set_reg(ins[11:9], read_word(ea));
			end
			OP_STI: begin
				ea = core_pc + sign_ext(ins, 9);
				ea = read_word(ea);
				core_mem[ea] = core_gpr[ins[11:9]];
			end
			OP_JMP: begin
				core_pc = core_gpr[ins[8:6]];
			end
			OP_LEA: begin
				set_reg(ins[11:9], core_pc + sign_ext(ins, 9));
			end
			OP_TRAP: begin
				case (ins[7:0])
					TRAP_GETC, TRAP_IN: begin
						if (!kb_ready) begin
							// no key: stay on the trap
							core_pc = at;
							ev = EV_WAIT;
						end else begin
							kb_taken = 1'b1;
							core_gpr[REG_LINK] = core_pc;
							set_reg(REG_R0, {8'h00, kb_char});
						end
					end
					TRAP_OUT, TRAP_PUTS, TRAP_PUTSP: begin
						core_gpr[REG_LINK] = core_pc;
						ev = (ins[7:0] == TRAP_OUT) ? EV_OUT :
							(ins[7:0] == TRAP_PUTS) ? EV_PUTS : EV_PUTSP;
						ev_value = core_gpr[REG_R0];
					end
					TRAP_HALT: begin
						core_gpr[REG_LINK] = core_pc;
						core_run = 1'b0;
						ev = EV_HALT;
					end
					default: begin
						core_run = 1'b0;
						ev = EV_BAD;
					end
				endcase
			end
			default: begin
				// RTI and the reserved opcode stop the core
				core_run = 1'b0;
				ev = EV_BAD;
			end
		endcase
	endfunction

	// Expected result of one accepted command beat
	function automatic step_result_t exec_command(input item_t it);
		step_result_t r;
		kb_ready = it.key_ready;
		kb_char = it.key_char;
		kb_taken = 1'b0;
		r.read_data = '0;
		r.ev = EV_NONE;
		r.ev_value = '0;
		case (it.command)
			CMD_WRITE: core_mem[it.address] = it.data;
			CMD_READ:  r.read_data = read_word(it.address);
			CMD_START: begin
				core_pc = start_pc;
				core_run = 1'b1;
			end
			default: begin
				if (core_run)
					run_insn(r.ev, r.ev_value);
			end
		endcase
		r.pc = core_pc;
		r.flags = core_cc;
		r.key_taken = kb_taken;
		r.running = core_run;
		return r;
	endfunction

	// Random idling, off during the hold-off and one quiet stretch
	function automatic bit sender_pauses();
		if (rx_hold > 0 || (beats_sent >= 200 && beats_sent < 320))
			return 1'b0;
		return $urandom_range(0, 99) < 37;
	endfunction

	function automatic bit receiver_pauses();
		if (results_seen >= 200 && results_seen < 320)
			return 1'b0;
		return $urandom_range(0, 99) < 37;
	endfunction

	// Clock, reset and initial input levels
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_WRITE;
		cmd_ch.address = '0;
		cmd_ch.data = '0;
		cmd_ch.key_ready = 1'b0;
		cmd_ch.key_char = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.start_address = '0;
		fork
			forever #6 clk = ~clk;
			begin
				repeat (4) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// Command driver: a beat is held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_results.push_back(exec_command(cur_cmd));
				beats_sent++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() > 0 && !sender_pauses()) begin
					cur_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.command <= cur_cmd.command;
					cmd_ch.address <= cur_cmd.address;
					cmd_ch.data <= cur_cmd.data;
					cmd_ch.key_ready <= cur_cmd.key_ready;
					cmd_ch.key_char <= cur_cmd.key_char;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_result();
		step_result_t want;
		if (expected_results.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: result beat with nothing expected, pc=%h ev=%0d",
					$time, res_ch.program_counter, res_ch.event_res);
			return;
		end
		want = expected_results.pop_front();
		open_items--;
		if (res_ch.read_data !== want.read_data || res_ch.program_counter !== want.pc ||
			res_ch.cond_flags !== want.flags || res_ch.event_res !== want.ev ||
			res_ch.event_value !== want.ev_value || res_ch.key_taken !== want.key_taken ||
			res_ch.running !== want.running) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10) begin
				$display("%0t: mismatch exp rd=%h pc=%h cc=%0d ev=%0d val=%h key=%b run=%b",
					$time, want.read_data, want.pc, want.flags, want.ev, want.ev_value,
					want.key_taken, want.running);
				$display("%0t:          got rd=%h pc=%h cc=%0d ev=%0d val=%h key=%b run=%b",
					$time, res_ch.read_data, res_ch.program_counter, res_ch.cond_flags,
					res_ch.event_res, res_ch.event_value, res_ch.key_taken, res_ch.running);
			end
		end
	endtask

	// Receiver hold-off: one long stretch to back up the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
			end else if (!hold_done && results_seen >= 40) begin
				hold_done <= 1'b1;
				rx_hold <= 250;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				check_result();
				results_seen++;
			end
			res_ch.ready <= (rx_hold > 0) ? 1'b0 : !receiver_pauses();
		end
	end

	task automatic queue_beat(input cmd_t c, input addr_t a, input word_t d,
		input logic kr, input logic [7:0] kc);
		item_t it;
		it.command = c;
		it.address = a;
		it.data = d;
		it.key_ready = kr;
		it.key_char = kc;
		pending_cmds.push_back(it);
		open_items++;
	endtask

	task automatic queue_random_key(input cmd_t c, input addr_t a, input word_t d);
		queue_beat(c, a, d, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		while (open_items != 0)
			@(posedge clk);
	endtask

	task automatic write_start_address(input word_t value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.start_address <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		start_pc = value;
	endtask

	// Random instruction word, weighted toward ordinary opcodes
	function automatic word_t random_insn();
		word_t       ins;
		int unsigned pick;
		op_t         op;
		ins = word_t'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			ins[15:12] = OP_TRAP;
			if ($urandom_range(0, 9) != 0)
				ins[7:0] = TRAP_GETC + 8'($urandom_range(0, 5));
		end else if (pick < 12) begin
			ins[15:12] = $urandom_range(0, 1) ? OP_RTI : OP_RES;
		end else begin
			do begin
				op = op_t'($urandom_range(0, 15));
			end while (op == OP_RTI || op == OP_RES || op == OP_TRAP);
			ins[15:12] = op;
			// PC-relative forms often land inside the program or its pointer words
			if ((op == OP_BR || op == OP_LD || op == OP_ST || op == OP_LDI ||
				op == OP_STI || op == OP_LEA) && $urandom_range(0, 1) == 1)
				ins[8:0] = 9'($urandom_range(0, 20)) - 9'd4;
		end
		return ins;
	endfunction

	// Random programs at the current start address, plus raw noise beats
	task automatic queue_program_phase(input int unsigned quota);
		int unsigned made;
		int unsigned len;
		int unsigned steps;
		addr_t       base;
		made = 0;
		while (made < quota) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_random_key(cmd_t'($urandom_range(0, 3)), addr_t'($urandom()),
					word_t'($urandom()));
				made++;
			end else begin
				base = start_pc;
				len = $urandom_range(2, 10);
				for (int unsigned i = 0; i < len; i++)
					queue_random_key(CMD_WRITE, base + addr_t'(i), random_insn());
				for (int unsigned i = 0; i < 3; i++)
					queue_random_key(CMD_WRITE, base + addr_t'(len + i),
						($urandom_range(0, 2) == 0) ? KBSR_ADDR :
						($urandom_range(0, 1) == 0) ? KBDR_ADDR : word_t'($urandom()));
				queue_random_key(CMD_START, addr_t'($urandom()), word_t'($urandom()));
				steps = len + $urandom_range(2, 8);
				for (int unsigned i = 0; i < steps; i++) begin
					// occasional host read while the program runs
					if ($urandom_range(0, 9) == 0) begin
						queue_random_key(CMD_READ, $urandom_range(0, 1) ? KBSR_ADDR :
							base + addr_t'($urandom_range(0, 15)), word_t'($urandom()));
						made++;
					end
					queue_random_key(CMD_STEP, addr_t'($urandom()), word_t'($urandom()));
				end
				made += len + 4 + steps;
			end
		end
	endtask

	// Stimulus
	initial begin
		wait (arst_n === 1'b1);

		// Directed: idle step, keyboard polls, extremes, traps and stops
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_READ, KBSR_ADDR, '0, 1'b1, 8'hFF);
		queue_beat(CMD_READ, KBDR_ADDR, '0, 1'b0, 8'h00);
		queue_beat(CMD_READ, KBSR_ADDR, '1, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, '1, '1, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET, {OP_TRAP, 4'h0, TRAP_GETC}, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET + 16'd1, {OP_JSR, 3'b000, REG_LINK, 6'd0},
			1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET + 16'd2, {OP_TRAP, 4'h0, TRAP_OUT}, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET + 16'd3, {OP_TRAP, 4'h0, 8'hFF}, 1'b0, 8'h00);
		queue_beat(CMD_START, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b1, 8'h80);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_READ, START_RESET, '0, 1'b1, 8'h41);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET, {OP_RTI, 12'h000}, 1'b0, 8'h00);
		queue_beat(CMD_START, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET, {OP_RES, 12'hFFF}, 1'b0, 8'h00);
		queue_beat(CMD_START, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_WRITE, START_RESET, {OP_TRAP, 4'h0, TRAP_HALT}, 1'b0, 8'h00);
		queue_beat(CMD_START, '0, '0, 1'b0, 8'h00);
		queue_beat(CMD_STEP, '0, '0, 1'b0, 8'h00);
		wait_drained();

		// Random programs at several start addresses, wrap and KBSR fetch among them
		write_start_address(16'hFFFF);
		queue_program_phase(115);
		wait_drained();
		write_start_address(16'h0000);
		queue_program_phase(115);
		wait_drained();
		write_start_address(KBSR_ADDR);
		queue_program_phase(110);
		wait_drained();
		write_start_address(word_t'($urandom()));
		queue_program_phase(115);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Run limit: covers the memory clearing pass and the slowest stall pattern
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/iexu_pkg.sv
hw/rtl/iexu_ifs.sv
hw/rtl/iexu_mem.sv
hw/rtl/iexu_regfile.sv
hw/rtl/lc3_instruction_executor_unit.sv
tb/lc3_instruction_executor_unit_tb.sv
